@@ hw/rtl/csod_pkg.sv @@
// csod_pkg: shared types and constants for the cascaded serial-in parallel-out driver
// no dependencies; imported by the interfaces and by every driver module but csod_queue
`default_nettype none

package csod_pkg;

  // default length of the register chain
  localparam int CHIPS_DEFAULT = 4;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_SET_BIT   = 2'd0,
    OP_LOAD_BYTE = 2'd1,
    OP_ENABLE    = 2'd2,
    OP_DISABLE   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARAM = 2'd1,
    ST_SAME  = 2'd2
  } status_t;

  // command passed from the front end to the shift engine
  typedef struct packed {
    logic    shift;   // shift the attached image out
    status_t status;  // status of a single-result command
    logic    enable;  // output-enable level after the operation
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/csod_if.sv @@
// csod_in_if / csod_out_if: valid-ready channels of the output driver
// depends on csod_pkg
`default_nettype none

interface csod_in_if
  import csod_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] bit_position;
  logic       bit_value;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, op, bit_position, bit_value, byte_value, last_byte,
                  input ready);
  modport sink   (input valid, op, bit_position, bit_value, byte_value, last_byte,
                  output ready);
endinterface

interface csod_out_if
  import csod_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       bit_valid;
  logic       serial_bit;
  logic       latch;
  logic       outputs_enabled;

  modport source (output valid, status, bit_valid, serial_bit, latch, outputs_enabled,
                  input ready);
  modport sink   (input valid, status, bit_valid, serial_bit, latch, outputs_enabled,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/csod_front.sv @@
// csod_front: accepts transactions, keeps image, staging, load count and enable level
// depends on csod_pkg and csod_in_if; feeds commands to csod_queue
`default_nettype none

module csod_front
  import csod_pkg::*;
#(
  parameter int CHIPS = CHIPS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  csod_in_if.sink                   in_ch,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cmd_t                      q_cmd,
  output logic [8*CHIPS-1:0]        q_img
);

  localparam int IMG_W = 8 * CHIPS;
  localparam int IDX_W = (IMG_W > 1) ? $clog2(IMG_W) : 1;
  localparam int LC_W  = $clog2(CHIPS + 2);
  localparam logic [4:0]      CHIP_LIMIT = 5'(CHIPS);
  localparam logic [LC_W-1:0] LC_CHIPS   = LC_W'(CHIPS);

  logic [IMG_W-1:0] image_r, image_nxt;
  logic [IMG_W-1:0] staging_r, staging_nxt;
  logic [LC_W-1:0]  load_count_r, load_count_nxt, load_count_inc;
  logic             enable_r, enable_nxt;
  logic             in_range;
  logic [IDX_W-1:0] bit_idx;
  op_t              op;
  cmd_t             cmd;

  assign op       = op_t'(in_ch.op);
  assign in_range = in_ch.bit_position[7:3] < CHIP_LIMIT;
  assign bit_idx  = in_ch.bit_position[IDX_W-1:0];

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // decode one transaction and work out the new state
  always_comb begin
    image_nxt      = image_r;
    staging_nxt    = staging_r;
    load_count_nxt = load_count_r;
    load_count_inc = load_count_r;
    enable_nxt     = enable_r;
    cmd.shift      = 1'b0;
    cmd.status     = ST_OK;
    unique case (op)
      OP_SET_BIT: begin
        if (!in_range) begin
          cmd.status = ST_PARAM;
        end else if (image_r[bit_idx] == in_ch.bit_value) begin
          cmd.status = ST_SAME;
        end else begin
          image_nxt[bit_idx] = in_ch.bit_value;
          cmd.shift          = 1'b1;
        end
      end
      OP_LOAD_BYTE: begin
        for (int i = 0; i < CHIPS; i++) begin
          if (load_count_r == LC_W'(i)) staging_nxt[8*i +: 8] = in_ch.byte_value;
        end
        if (load_count_r <= LC_CHIPS) load_count_inc = load_count_r + 1'b1;
        load_count_nxt = load_count_inc;
        if (in_ch.last_byte) begin
          load_count_nxt = '0;
          if (load_count_inc == LC_CHIPS) begin
            image_nxt = staging_nxt;
            cmd.shift = 1'b1;
          end else begin
            cmd.status = ST_PARAM;
          end
        end
      end
      OP_ENABLE:  enable_nxt = 1'b1;
      OP_DISABLE: enable_nxt = 1'b0;
      default:    enable_nxt = enable_r;
    endcase
    cmd.enable = enable_nxt;
  end

  assign q_cmd = cmd;
  assign q_img = image_nxt;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r      <= '0;
      load_count_r <= '0;
      enable_r     <= 1'b0;
    end else if (q_push) begin
      image_r      <= image_nxt;
      load_count_r <= load_count_nxt;
      enable_r     <= enable_nxt;
    end
  end

  // staging bytes are only read after being written in the same load
  always_ff @(posedge clk) begin
    if (q_push) staging_r <= staging_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/csod_queue.sv @@
// csod_queue: two-entry command queue between front end and shift engine
// no dependencies; generic payload width
`default_nettype none

module csod_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;
  assign pop_data = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

@@ hw/rtl/csod_back.sv @@
// csod_back: shift engine that turns queued commands into result transactions
// depends on csod_pkg and csod_out_if; fed by csod_queue
`default_nettype none

module csod_back
  import csod_pkg::*;
#(
  parameter int CHIPS = CHIPS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  cmd_t                      q_cmd,
  input  wire logic [8*CHIPS-1:0]   q_img,
  output logic                      q_pop,
  csod_out_if.source                out_ch
);

  localparam int IMG_W = 8 * CHIPS;
  localparam int CNT_W = $clog2(IMG_W + 1);

  logic [IMG_W-1:0] shreg_r;
  logic [CNT_W-1:0] count_r;
  logic             active_r;
  logic             shift_en_r;
  logic             out_valid_r;
  status_t          status_r;
  logic             bit_valid_r, serial_r, latch_r, enabled_r;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = slot_free && !active_r && !q_empty;

  // shifter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (active_r) begin
        out_valid_r <= 1'b1;
        status_r    <= ST_OK;
        bit_valid_r <= 1'b1;
        serial_r    <= shreg_r[IMG_W-1];
        latch_r     <= count_r == CNT_W'(1);
        enabled_r   <= shift_en_r;
        shreg_r     <= shreg_r << 1;
        count_r     <= count_r - 1'b1;
        active_r    <= count_r != CNT_W'(1);
      end else if (!q_empty) begin
        if (q_cmd.shift) begin
          out_valid_r <= 1'b0;
          shreg_r     <= q_img;
          count_r     <= CNT_W'(IMG_W);
          shift_en_r  <= q_cmd.enable;
          active_r    <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
          status_r    <= q_cmd.status;
          bit_valid_r <= 1'b0;
          serial_r    <= 1'b0;
          latch_r     <= 1'b0;
          enabled_r   <= q_cmd.enable;
        end
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.bit_valid       = bit_valid_r;
  assign out_ch.serial_bit      = serial_r;
  assign out_ch.latch           = latch_r;
  assign out_ch.outputs_enabled = enabled_r;

  // checks
  a_latch_on_bit: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && latch_r) |-> bit_valid_r)
    else $error("latch marker without a shifted bit");
  a_bit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && bit_valid_r) |-> status_r == ST_OK)
    else $error("shifted bit with failing status");
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
      active_r |-> count_r != '0)
    else $error("shifter active with empty count");
  a_latch_ends: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && latch_r) |-> !active_r)
    else $error("shifter still active after latch bit");

endmodule

`default_nettype wire

@@ hw/rtl/cascaded_sipo_output_driver.sv @@
// Output driver for a chain of CHIPS cascaded 8-bit serial-in parallel-out registers.
// A set-bit, load-byte, enable or disable transaction enters on in_ch and is
// decoded combinationally by the front end, which updates the output image and pushes
// a command into a two-entry queue; in_ch.ready is low only while that queue is full.
// The shift engine behind the queue emits at most one result per cycle on out_ch:
// a single status result for most operations, or 8*CHIPS serial bits (last chip first,
// MSB first, latch on the final bit) after a successful write. A shifting write holds
// the engine until its last bit has gone out, as the shifter moves one bit per result,
// and it pops no other command meanwhile. Back-pressure on out_ch stalls only the
// engine until the queue fills.
// depends on csod_pkg, csod_if, csod_front, csod_queue and csod_back
`default_nettype none

module cascaded_sipo_output_driver
  import csod_pkg::*;
#(
  parameter int CHIPS = CHIPS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  csod_in_if.sink    in_ch,
  csod_out_if.source out_ch
);

  localparam int IMG_W = 8 * CHIPS;
  localparam int Q_W   = $bits(cmd_t) + IMG_W;

  logic             q_push, q_pop, q_full, q_empty;
  cmd_t             f_cmd, b_cmd;
  logic [IMG_W-1:0] f_img, b_img;
  logic [Q_W-1:0]   q_out;

  // decode and state update
  csod_front #(.CHIPS(CHIPS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (f_cmd),
    .q_img  (f_img)
  );

  // command queue
  csod_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_cmd, f_img}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign b_cmd = cmd_t'(q_out[Q_W-1:IMG_W]);
  assign b_img = q_out[IMG_W-1:0];

  // shift engine
  csod_back #(.CHIPS(CHIPS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (b_cmd),
    .q_img   (b_img),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for cascaded_sipo_output_driver; predicts every result from its own
// copy of the output image and checks the out channel transaction by transaction
// depends on csod_pkg, csod_if and the driver rtl
`default_nettype none

module tb;
  import csod_pkg::*;

  localparam int CHIPS       = CHIPS_DEFAULT;
  localparam int ITEM_TARGET = 260;

  // one expected transaction on the result channel
  typedef struct {
    status_t status;
    logic    bit_valid;
    logic    serial_bit;
    logic    latch;
    logic    outputs_enabled;
  } drv_result_t;

  logic clk = 1'b0;
  logic rst_n;

  csod_in_if  in_ch ();
  csod_out_if out_ch ();

  cascaded_sipo_output_driver #(.CHIPS(CHIPS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predicted driver state
  logic [7:0]  image_bits [CHIPS];
  logic [7:0]  staged_bytes [CHIPS];
  logic [3:0]  bytes_staged;
  logic        enable_level;
  drv_result_t pending_outputs [$];

  // run bookkeeping
  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int shifted_seen  = 0;
  bit gaps_on       = 1'b0;
  int hold_request  = 0;
  int stall_left    = 0;

  // random gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_status(status_t st);
    drv_result_t r;
    r.status          = st;
    r.bit_valid       = 1'b0;
    r.serial_bit      = 1'b0;
    r.latch           = 1'b0;
    r.outputs_enabled = enable_level;
    pending_outputs.push_back(r);
  endfunction

  // whole image goes out last chip first, msb first, latch on chip 0 bit 0
  function automatic void queue_image_shift();
    drv_result_t r;
    for (int chip = CHIPS - 1; chip >= 0; chip--) begin
      for (int j = 7; j >= 0; j--) begin
        r.status          = ST_OK;
        r.bit_valid       = 1'b1;
        r.serial_bit      = image_bits[chip][j];
        r.latch           = (chip == 0 && j == 0);
        r.outputs_enabled = enable_level;
        pending_outputs.push_back(r);
      end
    end
  endfunction

  // update the predicted state for one accepted transaction and queue its results
  function automatic void apply_driver_op(op_t op, logic [7:0] pos, logic val,
                                          logic [7:0] byte_v, logic last);
    int chip;
    int sh;
    chip = pos >> 3;
    sh   = pos[2:0];
    case (op)
      OP_SET_BIT: begin
        if (chip >= CHIPS) begin
          queue_status(ST_PARAM);
        end else if (image_bits[chip][sh] == val) begin
          queue_status(ST_SAME);
        end else begin
          image_bits[chip][sh] = val;
          queue_image_shift();
        end
      end
      OP_LOAD_BYTE: begin
        if (bytes_staged < CHIPS) staged_bytes[bytes_staged] = byte_v;
        if (bytes_staged <= CHIPS) bytes_staged++;
        if (!last) begin
          queue_status(ST_OK);
        end else if (bytes_staged == CHIPS) begin
          bytes_staged = '0;
          image_bits   = staged_bytes;
          queue_image_shift();
        end else begin
          bytes_staged = '0;
          queue_status(ST_PARAM);
        end
      end
      OP_ENABLE: begin
        enable_level = 1'b1;
        queue_status(ST_OK);
      end
      default: begin
        enable_level = 1'b0;
        queue_status(ST_OK);
      end
    endcase
  endfunction

  // offer one transaction, hold it until accepted, then predict it
  task automatic send_cmd(op_t op, logic [7:0] pos, logic val, logic [7:0] byte_v,
                          logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.bit_position <= pos;
    in_ch.bit_value    <= val;
    in_ch.byte_value   <= byte_v;
    in_ch.last_byte    <= last;
    do @(posedge clk); while (!in_ch.ready);
    apply_driver_op(op, pos, val, byte_v, last);
    items_sent++;
  endtask

  task automatic set_bit(logic [7:0] pos, logic val);
    send_cmd(OP_SET_BIT, pos, val, 8'($urandom), 1'($urandom));
  endtask

  task automatic load_byte(logic [7:0] byte_v, logic last);
    send_cmd(OP_LOAD_BYTE, 8'($urandom), 1'($urandom), byte_v, last);
  endtask

  task automatic set_enable(logic on);
    send_cmd(on ? OP_ENABLE : OP_DISABLE, 8'($urandom), 1'($urandom), 8'($urandom),
             1'($urandom));
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  // result side ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    drv_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.bit_valid) shifted_seen++;
      if (pending_outputs.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("tb: unexpected result at %0t: st=%0d bv=%0d sb=%0d la=%0d oe=%0d",
                   $realtime, out_ch.status, out_ch.bit_valid, out_ch.serial_bit,
                   out_ch.latch, out_ch.outputs_enabled);
      end else begin
        exp_r = pending_outputs.pop_front();
        if (out_ch.status !== exp_r.status || out_ch.bit_valid !== exp_r.bit_valid ||
            out_ch.serial_bit !== exp_r.serial_bit || out_ch.latch !== exp_r.latch ||
            out_ch.outputs_enabled !== exp_r.outputs_enabled) begin
          error_count++;
          if (error_count <= 10)
            $display("tb: mismatch at %0t: exp st=%0d bv=%0d sb=%0d la=%0d oe=%0d, got st=%0d bv=%0d sb=%0d la=%0d oe=%0d",
                     $realtime, exp_r.status, exp_r.bit_valid, exp_r.serial_bit,
                     exp_r.latch, exp_r.outputs_enabled, out_ch.status,
                     out_ch.bit_valid, out_ch.serial_bit, out_ch.latch,
                     out_ch.outputs_enabled);
        end
      end
    end
  end

  // enable and disable, both op codes at the top of the range
  task automatic test_enable_ops();
    set_enable(1'b1);
    set_enable(1'b0);
    set_enable(1'b1);
  endtask

  // set bit: change, no change, both ends of the chain, out of range positions
  task automatic test_set_bit_cases();
    set_bit(8'd0, 1'b1);
    set_bit(8'd0, 1'b1);
    set_bit(8'(8 * CHIPS - 1), 1'b1);
    set_bit(8'(8 * CHIPS), 1'b1);
    set_bit(8'd255, 1'b1);
    set_bit(8'(8 * CHIPS - 1), 1'b0);
    set_bit(8'd7, 1'b0);
  endtask

  // whole image load, short load, overlong load, lone closing byte
  task automatic test_image_loads();
    for (int k = 0; k < CHIPS; k++)
      load_byte(k[0] ? 8'h00 : 8'hff, k == CHIPS - 1);
    load_byte(8'ha5, 1'b0);
    load_byte(8'h5a, 1'b1);
    for (int k = 0; k < CHIPS + 2; k++)
      load_byte(8'($urandom), k == CHIPS + 1);
    load_byte(8'h3c, 1'b1);
    wait_drained();
  endtask

  // other operations in the middle of a load leave it open
  task automatic test_interrupted_load();
    load_byte(8'h81, 1'b0);
    set_enable(1'b0);
    load_byte(8'h42, 1'b0);
    set_bit(8'd3, 1'b1);
    for (int k = 2; k < CHIPS; k++)
      load_byte(8'($urandom), k == CHIPS - 1);
    wait_drained();
  endtask

  // long result stall while the sender keeps offering, so the input stalls too
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 400;
    for (int k = 0; k < 12; k++) begin
      if (k % 4 == 3) set_enable(k[2]);
      else set_bit(8'($urandom_range(0, 8 * CHIPS - 1)), 1'($urandom));
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // mostly well formed loads and in-range set bits, with broken loads and noise
  task automatic test_random();
    int pick;
    int len;
    gaps_on = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        for (int k = 0; k < CHIPS; k++) begin
          if ($urandom_range(0, 9) == 0) set_enable(1'($urandom));
          load_byte(8'($urandom), k == CHIPS - 1);
        end
      end else if (pick < 65) begin
        set_bit(8'($urandom_range(0, 8 * CHIPS - 1)), 1'($urandom));
      end else if (pick < 75) begin
        set_bit(8'($urandom_range(0, 255)), 1'($urandom));
      end else if (pick < 87) begin
        set_enable(1'($urandom));
      end else begin
        len = $urandom_range(1, CHIPS + 3);
        if (len == CHIPS) len++;
        for (int k = 0; k < len; k++)
          load_byte(8'($urandom), k == len - 1);
      end
    end
    wait_drained();
  endtask

  // sequence of tests and final verdict
  initial begin
    image_bits         = '{default: 8'h00};
    staged_bytes       = '{default: 8'h00};
    bytes_staged       = '0;
    enable_level       = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SET_BIT;
    in_ch.bit_position = '0;
    in_ch.bit_value    = 1'b0;
    in_ch.byte_value   = '0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_enable_ops();
    test_set_bit_cases();
    test_image_loads();
    test_interrupted_load();
    test_backpressure();
    test_random();

    // let any stray result show up before the verdict
    repeat (50) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked, %0d of them shifted bits",
             items_sent, results_seen, shifted_seen);
    $display("tb: set/same/range cases, full and broken loads, enable toggles, long stall");
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("tb: timeout, %0d results still expected", pending_outputs.size());
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
